// ----- rtl/core/sha1_pkg.sv -----
`timescale 1ns / 1ps

package sha1_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [31:0] PAD_WORD = 32'h80000000;
    localparam int          QUEUE_DEPTH = 2;

    // Kinds of words handed from the front end to the compression engine.
    typedef enum logic [1:0] {
        WK_DATA  = 2'd0,  // plain message word
        WK_FINAL = 2'd1   // last word, byte count already saturated
    } t_word_kind;

    // One queued word: data, valid byte count and kind.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        t_word_kind  kind;
    } t_qword;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        begin
            d = {x, x} << n;
            rotl = d[63:32];
        end
    endfunction

endpackage

// ----- rtl/core/sha1_front.sv -----
`timescale 1ns / 1ps

module sha1_front #(
    parameter int DEPTH = sha1_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [31:0]     i_word,
    input  logic [2:0]      i_byte_count,
    input  logic            i_last,
    input  logic            i_push,
    output logic            o_full,
    output sha1_pkg::t_qword o_qword,
    output logic            o_qvalid,
    input  logic            i_qtake
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha1_pkg::t_qword r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [AW:0]   r_cnt, n_cnt;
    sha1_pkg::t_qword w_in;
    logic do_push, do_pop;

    // Classify the incoming word and saturate the byte count.
    always_comb begin
        w_in.word   = i_word;
        w_in.kind   = i_last ? sha1_pkg::WK_FINAL : sha1_pkg::WK_DATA;
        w_in.nbytes = (!i_last || i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
    end

    assign o_full   = (r_cnt == (AW+1)'(DEPTH));
    assign o_qvalid = (r_cnt != '0);
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_qtake && o_qvalid;
    assign o_qword  = r_mem[r_rp];

    // Pointer and count updates.
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
        end
        n_cnt = r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= w_in;
        end
    end

endmodule

// ----- rtl/core/sha1_engine.sv -----
`timescale 1ns / 1ps

module sha1_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sha1_pkg::t_qword i_qword,
    input  logic             i_qvalid,
    output logic             o_qtake,
    output logic [31:0]      o_digest_a,
    output logic [31:0]      o_digest_b,
    output logic [31:0]      o_digest_c,
    output logic [31:0]      o_digest_d,
    output logic [31:0]      o_digest_e,
    output logic             o_empty,
    input  logic             i_pop
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,  // waiting for a word
        S_PAD   = 4'b0010,  // inserting padding and length words
        S_ROUND = 4'b0100,  // running the 80 rounds
        S_DONE  = 4'b1000   // digest waiting in the output register
    } t_state;

    t_state r_state, n_state;
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [16];
    logic [3:0]  r_pos;
    logic [63:0] r_len;
    logic [6:0]  r_t;
    logic        r_fin;      // padding in progress
    logic        r_padlast;  // compression in progress is the final one
    logic        r_need80;   // 0x80 word still has to be inserted
    logic        r_full;
    logic [31:0] r_out [5];

    logic [31:0] w_f, w_k, w_wt, w_wnew, w_tmp;
    logic [31:0] w_mask, w_padw, w_insert;
    logic        w_take, w_ins;
    logic [63:0] w_len_next;
    logic [5:0]  w_bits;

    // Round function, constant and schedule word.
    always_comb begin
        if (r_t < 7'd20) begin
            w_f = (r_b & r_c) ^ (~r_b & r_d);
            w_k = sha1_pkg::K0;
        end else if (r_t < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = sha1_pkg::K1;
        end else if (r_t < 7'd60) begin
            w_f = (r_b & r_c) ^ (r_b & r_d) ^ (r_c & r_d);
            w_k = sha1_pkg::K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = sha1_pkg::K3;
        end
        w_wnew = sha1_pkg::rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 5'd1);
        w_wt   = (r_t < 7'd16) ? r_w[0] : w_wnew;
        w_tmp  = sha1_pkg::rotl(r_a, 5'd5) + w_f + r_e + w_k + w_wt;
    end

    // Final-word masking and padding byte placement.
    always_comb begin
        w_bits = {i_qword.nbytes, 3'b000};
        w_mask = (i_qword.nbytes == 3'd0) ? 32'd0 : ~(32'hFFFFFFFF >> w_bits);
        w_padw = (i_qword.word & w_mask) | (sha1_pkg::PAD_WORD >> w_bits);
        w_len_next = r_len + 64'(w_bits);
    end

    // Word to insert in this cycle.
    always_comb begin
        w_take   = 1'b0;
        w_ins    = 1'b0;
        w_insert = '0;
        if (r_state == S_IDLE && i_qvalid) begin
            w_take = 1'b1;
            w_ins  = 1'b1;
            if (i_qword.kind == sha1_pkg::WK_FINAL && i_qword.nbytes != 3'd4) begin
                w_insert = w_padw;
            end else begin
                w_insert = i_qword.word;
            end
        end else if (r_state == S_PAD) begin
            w_ins = 1'b1;
            if (r_need80) begin
                w_insert = sha1_pkg::PAD_WORD;
            end else if (r_padlast && r_pos == 4'd14) begin
                w_insert = r_len[63:32];
            end else if (r_padlast && r_pos == 4'd15) begin
                w_insert = r_len[31:0];
            end else begin
                w_insert = '0;
            end
        end
    end
    assign o_qtake = w_take;

    // Control sequencing.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_qvalid) begin
                    if (r_pos == 4'd15) begin
                        n_state = S_ROUND;
                    end else if (i_qword.kind == sha1_pkg::WK_FINAL) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_pos == 4'd15) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (r_t == 7'd80) begin
                    // The final update waits until the previous digest is taken.
                    if (r_fin && r_padlast) begin
                        if (!r_full) begin
                            n_state = S_DONE;
                        end
                    end else if (r_fin) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DONE: begin
                if (!r_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_h[0]    <= sha1_pkg::IV0;
            r_h[1]    <= sha1_pkg::IV1;
            r_h[2]    <= sha1_pkg::IV2;
            r_h[3]    <= sha1_pkg::IV3;
            r_h[4]    <= sha1_pkg::IV4;
            r_pos     <= '0;
            r_len     <= '0;
            r_t       <= '0;
            r_fin     <= 1'b0;
            r_padlast <= 1'b0;
            r_need80  <= 1'b0;
            r_full    <= 1'b0;
            r_a <= '0; r_b <= '0; r_c <= '0; r_d <= '0; r_e <= '0;
        end else begin
            r_state <= n_state;
            if (i_pop && r_full) begin
                r_full <= 1'b0;
            end
            // Word insertion into the schedule window.
            if (w_ins) begin
                r_pos <= r_pos + 1'b1;
                if (w_take) begin
                    if (i_qword.kind == sha1_pkg::WK_FINAL) begin
                        r_len     <= w_len_next;
                        r_fin     <= 1'b1;
                        r_need80  <= (i_qword.nbytes == 3'd4);
                        r_padlast <= (r_pos < 4'd13) ||
                                     (r_pos == 4'd13 && i_qword.nbytes != 3'd4);
                    end else begin
                        r_len <= r_len + 64'd32;
                    end
                end else if (r_need80) begin
                    r_need80  <= 1'b0;
                    r_padlast <= (r_pos < 4'd14);
                end
                if (r_pos == 4'd15) begin
                    r_t <= '0;
                    r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                    r_d <= r_h[3]; r_e <= r_h[4];
                end
            end
            // One round per cycle, then the chaining update.
            if (r_state == S_ROUND) begin
                if (r_t == 7'd80) begin
                    if (r_fin && r_padlast) begin
                        if (!r_full) begin
                            r_h[0] <= sha1_pkg::IV0;
                            r_h[1] <= sha1_pkg::IV1;
                            r_h[2] <= sha1_pkg::IV2;
                            r_h[3] <= sha1_pkg::IV3;
                            r_h[4] <= sha1_pkg::IV4;
                            r_len  <= '0;
                            r_fin  <= 1'b0;
                        end
                    end else begin
                        r_h[0] <= r_h[0] + r_a;
                        r_h[1] <= r_h[1] + r_b;
                        r_h[2] <= r_h[2] + r_c;
                        r_h[3] <= r_h[3] + r_d;
                        r_h[4] <= r_h[4] + r_e;
                        r_padlast <= 1'b1;
                    end
                end else begin
                    r_t <= r_t + 1'b1;
                    r_e <= r_d;
                    r_d <= r_c;
                    r_c <= sha1_pkg::rotl(r_b, 5'd30);
                    r_b <= r_a;
                    r_a <= w_tmp;
                end
            end
            if (r_state == S_DONE && !r_full) begin
                r_full <= 1'b1;
            end
        end
    end

    // Schedule window: written in order, then shifted once per round.
    always_ff @(posedge i_clk) begin
        if (w_ins) begin
            r_w[r_pos] <= w_insert;
        end else if (r_state == S_ROUND && r_t != 7'd80) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_wt;
        end
    end

    // Digest register: final chaining value captured at the final chaining update.
    always_ff @(posedge i_clk) begin
        if (r_state == S_ROUND && r_t == 7'd80 && r_fin && r_padlast && !r_full) begin
            r_out[0] <= r_h[0] + r_a;
            r_out[1] <= r_h[1] + r_b;
            r_out[2] <= r_h[2] + r_c;
            r_out[3] <= r_h[3] + r_d;
            r_out[4] <= r_h[4] + r_e;
        end
    end

    assign o_empty    = !r_full;
    assign o_digest_a = r_out[0];
    assign o_digest_b = r_out[1];
    assign o_digest_c = r_out[2];
    assign o_digest_d = r_out[3];
    assign o_digest_e = r_out[4];

endmodule

// ----- rtl/core/sha1_hash_core.sv -----
`timescale 1ns / 1ps

// Channel | Direction | Handshake     | Payload
// input   | in        | i_push/o_full | i_word, i_byte_count, i_last
// digest  | out       | o_empty/i_pop | o_digest_a .. o_digest_e
//
// A plain word is written into the schedule window; every 16th word starts the 80 rounds,
// one round per cycle in the shared compression unit, then the chaining update.
// A last word adds padding words and one or two compressions before the digest.
// Reset is synchronous and active low; the schedule window is not cleared.
// A small queue lets words arrive while the rounds run; a waiting digest
// stalls only the next message's final compression.
module sha1_hash_core #(
    parameter int QDEPTH = sha1_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last,
    input  logic        i_push,
    output logic        o_full,
    output logic [31:0] o_digest_a,
    output logic [31:0] o_digest_b,
    output logic [31:0] o_digest_c,
    output logic [31:0] o_digest_d,
    output logic [31:0] o_digest_e,
    output logic        o_empty,
    input  logic        i_pop
);

    sha1_pkg::t_qword w_qword;
    logic w_qvalid, w_qtake;

    // Front end: classifies words and buffers them.
    sha1_front #(.DEPTH(QDEPTH)) u_front (
        .i_clk, .i_rst_n, .i_word, .i_byte_count, .i_last, .i_push, .o_full,
        .o_qword(w_qword), .o_qvalid(w_qvalid), .i_qtake(w_qtake)
    );

    // Back end: padding, compression and digest register.
    sha1_engine u_engine (
        .i_clk, .i_rst_n, .i_qword(w_qword), .i_qvalid(w_qvalid),
        .o_qtake(w_qtake), .o_digest_a, .o_digest_b, .o_digest_c,
        .o_digest_d, .o_digest_e, .o_empty, .i_pop
    );

endmodule

// ----- sim/sha1_hash_core_test.sv -----
`timescale 1ns / 1ps

// Scoreboard that keeps its own SHA-1 state and a queue of expected digests.
class sha1_digest_board;
    logic [31:0] chain [5];
    logic [31:0] sched [16];
    int unsigned slot;
    logic [63:0] nbits;
    logic [159:0] pending_digests [$];
    int unsigned errors;

    function new();
        errors = 0;
        restart();
    endfunction

    function void restart();
        chain[0] = sha1_pkg::IV0;
        chain[1] = sha1_pkg::IV1;
        chain[2] = sha1_pkg::IV2;
        chain[3] = sha1_pkg::IV3;
        chain[4] = sha1_pkg::IV4;
        slot = 0;
        nbits = '0;
    endfunction

    static function logic [31:0] rol(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Runs the 80 rounds over the full window and folds them into the chain.
    function void compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        w = sched;
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int r = 0; r < 80; r++) begin
            if (r >= 16)
                w[r % 16] = rol(w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16]
                                ^ w[r % 16], 1);
            if (r <= 19) begin
                f = (b & c) ^ (~b & d); k = sha1_pkg::K0;
            end else if (r <= 39) begin
                f = b ^ c ^ d; k = sha1_pkg::K1;
            end else if (r <= 59) begin
                f = (b & c) ^ (b & d) ^ (c & d); k = sha1_pkg::K2;
            end else begin
                f = b ^ c ^ d; k = sha1_pkg::K3;
            end
            t = rol(a, 5) + f + e + k + w[r % 16];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    function void load(logic [31:0] v);
        sched[slot] = v;
        slot = (slot + 1) % 16;
        if (slot == 0)
            compress();
    endfunction

    // Notes one accepted word; the last word pads and queues a digest.
    function void note_word(logic [31:0] word, logic [2:0] cnt, logic last);
        int unsigned n;
        logic [31:0] mask;
        if (!last) begin
            nbits += 32;
            load(word);
            return;
        end
        n = (cnt > 4) ? 4 : cnt;
        nbits += 8 * n;
        if (n == 4) begin
            load(word);
            load(sha1_pkg::PAD_WORD);
        end else begin
            mask = (n == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - 8 * n));
            load((word & mask) | (32'h80 << (24 - 8 * n)));
        end
        if (slot > 14)
            while (slot != 0) load(32'h0);
        while (slot < 14) load(32'h0);
        load(nbits[63:32]);
        load(nbits[31:0]);
        pending_digests.push_back({chain[0], chain[1], chain[2], chain[3], chain[4]});
        restart();
    endfunction

    // Compares one accepted digest with the oldest expectation.
    function void check_digest(logic [159:0] got);
        logic [159:0] want;
        if (pending_digests.size() == 0) begin
            $display("%t: unexpected digest %h", $time, got);
            errors++;
            return;
        end
        want = pending_digests.pop_front();
        for (int i = 4; i >= 0; i--)
            if (want[i*32 +: 32] !== got[i*32 +: 32]) begin
                $display("%t: digest word %0d expected %h actual %h",
                         $time, 4 - i, want[i*32 +: 32], got[i*32 +: 32]);
                errors++;
            end
    endfunction
endclass

module sha1_hash_core_test;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [31:0] i_word = '0;
    logic [2:0]  i_byte_count = '0;
    logic        i_last = 1'b0;
    logic        i_push = 1'b0;
    logic        i_pop = 1'b0;
    logic        o_full, o_empty;
    logic [31:0] o_digest_a, o_digest_b, o_digest_c, o_digest_d, o_digest_e;

    sha1_digest_board board = new();
    int unsigned words_sent = 0;
    bit sending_done = 1'b0;

    sha1_hash_core dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mostly no gap, often a short one, sometimes a long one.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 200);
    endfunction

    // Offers one word and holds it until accepted; push drops only for a gap.
    task automatic send_word(logic [31:0] w, logic [2:0] cnt, logic last);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_word <= w;
        i_byte_count <= cnt;
        i_last <= last;
        i_push <= 1'b1;
        do @(posedge i_clk); while (o_full);
        board.note_word(w, cnt, last);
        words_sent++;
    endtask

    task automatic send_message(int unsigned nwords, logic [2:0] tail);
        for (int i = 0; i < nwords; i++)
            send_word($urandom, 3'($urandom), 1'b0);
        send_word($urandom, tail, 1'b1);
    endtask

    // Stops sending and waits until every expected digest has been taken.
    task automatic drain();
        i_push <= 1'b0;
        @(posedge i_clk);
        while (board.pending_digests.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random pop stalls, digests checked at accepting edges.
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty)
            board.check_digest({o_digest_a, o_digest_b, o_digest_c, o_digest_d, o_digest_e});
        if (!i_rst_n)
            i_pop <= 1'b0;
        else if ($urandom_range(0, 99) < 6)
            i_pop <= 1'b0;
        else if ($urandom_range(0, 99) < 2)
            i_pop <= 1'b0;
        else
            i_pop <= ($urandom_range(0, 99) < 75);
    end

    // Stimulus: directed corner messages, then random messages.
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_word(32'h0, 3'd0, 1'b1);
        send_word(32'h61626300, 3'd3, 1'b1);
        send_word(32'hFFFFFFFF, 3'd4, 1'b1);
        send_word(32'hFFFFFFFF, 3'd7, 1'b1);
        send_word(32'hFFFFFFFF, 3'd1, 1'b1);
        send_word(32'h12345678, 3'd2, 1'b1);
        send_message(13, 3'd4);
        send_message(13, 3'd0);
        send_message(14, 3'd3);
        send_message(15, 3'd5);
        drain();
        while (words_sent < 1950) begin
            if ($urandom_range(0, 9) == 0)
                send_message($urandom_range(0, 40), 3'($urandom));
            else
                send_message($urandom_range(0, 20), 3'($urandom_range(0, 4)));
            if ($urandom_range(0, 30) == 0)
                drain();
        end
        drain();
        repeat (300) @(posedge i_clk);
        if (board.errors == 0 && board.pending_digests.size() == 0)
            $display("[sha1_hash_core] OK");
        else
            $display("[sha1_hash_core] ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("[sha1_hash_core] ERROR");
        $finish;
    end
endmodule
